[hdl/sha_pkg.sv]
// ----------------------------------------------------------------------------
// SHA-256 hasher package
// Shared types, round constants and bit-mixing functions.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

package sha_pkg;

  // Controller states, one-hot.
  typedef enum logic [8:0] {
    S_INIT  = 9'b000000001,
    S_IDLE  = 9'b000000010,
    S_PAD   = 9'b000000100,
    S_LOAD  = 9'b000001000,
    S_ROUND = 9'b000010000,
    S_WB    = 9'b000100000,
    S_ORD   = 9'b001000000,
    S_OLD   = 9'b010000000,
    S_OUT   = 9'b100000000
  } sha_state_t;

  // Controls from the sequencer to the round datapath.
  typedef struct packed {
    logic       load_w;   // shift one schedule word in from the block memory
    logic       load_v;   // load one working variable from the chaining memory
    logic [2:0] v_idx;    // which working variable to load or read out
    logic       round;    // run one compression round
    logic [5:0] rnd;      // round number
  } sha_core_ctl_t;

  localparam logic [7:0] PAD_BYTE = 8'h80;
  localparam logic [5:0] LEN_POS  = 6'd56;

  function automatic logic [31:0] rotr(input logic [31:0] x, input int n);
    rotr = (x >> n) | (x << (32 - n));
  endfunction

  function automatic logic [31:0] big_sig0(input logic [31:0] x);
    big_sig0 = rotr(x, 2) ^ rotr(x, 13) ^ rotr(x, 22);
  endfunction

  function automatic logic [31:0] big_sig1(input logic [31:0] x);
    big_sig1 = rotr(x, 6) ^ rotr(x, 11) ^ rotr(x, 25);
  endfunction

  function automatic logic [31:0] sml_sig0(input logic [31:0] x);
    sml_sig0 = rotr(x, 7) ^ rotr(x, 18) ^ (x >> 3);
  endfunction

  function automatic logic [31:0] sml_sig1(input logic [31:0] x);
    sml_sig1 = rotr(x, 17) ^ rotr(x, 19) ^ (x >> 10);
  endfunction

  function automatic logic [31:0] init_h(input logic [2:0] i);
    logic [31:0] r;
    case (i)
      3'd0: r = 32'h6a09e667;
      3'd1: r = 32'hbb67ae85;
      3'd2: r = 32'h3c6ef372;
      3'd3: r = 32'ha54ff53a;
      3'd4: r = 32'h510e527f;
      3'd5: r = 32'h9b05688c;
      3'd6: r = 32'h1f83d9ab;
      default: r = 32'h5be0cd19;
    endcase
    return r;
  endfunction

  function automatic logic [31:0] round_k(input logic [5:0] i);
    logic [31:0] r;
    case (i)
      6'd0:  r = 32'h428a2f98;  6'd1:  r = 32'h71374491;
      6'd2:  r = 32'hb5c0fbcf;  6'd3:  r = 32'he9b5dba5;
      6'd4:  r = 32'h3956c25b;  6'd5:  r = 32'h59f111f1;
      6'd6:  r = 32'h923f82a4;  6'd7:  r = 32'hab1c5ed5;
      6'd8:  r = 32'hd807aa98;  6'd9:  r = 32'h12835b01;
      6'd10: r = 32'h243185be;  6'd11: r = 32'h550c7dc3;
      6'd12: r = 32'h72be5d74;  6'd13: r = 32'h80deb1fe;
      6'd14: r = 32'h9bdc06a7;  6'd15: r = 32'hc19bf174;
      6'd16: r = 32'he49b69c1;  6'd17: r = 32'hefbe4786;
      6'd18: r = 32'h0fc19dc6;  6'd19: r = 32'h240ca1cc;
      6'd20: r = 32'h2de92c6f;  6'd21: r = 32'h4a7484aa;
      6'd22: r = 32'h5cb0a9dc;  6'd23: r = 32'h76f988da;
      6'd24: r = 32'h983e5152;  6'd25: r = 32'ha831c66d;
      6'd26: r = 32'hb00327c8;  6'd27: r = 32'hbf597fc7;
      6'd28: r = 32'hc6e00bf3;  6'd29: r = 32'hd5a79147;
      6'd30: r = 32'h06ca6351;  6'd31: r = 32'h14292967;
      6'd32: r = 32'h27b70a85;  6'd33: r = 32'h2e1b2138;
      6'd34: r = 32'h4d2c6dfc;  6'd35: r = 32'h53380d13;
      6'd36: r = 32'h650a7354;  6'd37: r = 32'h766a0abb;
      6'd38: r = 32'h81c2c92e;  6'd39: r = 32'h92722c85;
      6'd40: r = 32'ha2bfe8a1;  6'd41: r = 32'ha81a664b;
      6'd42: r = 32'hc24b8b70;  6'd43: r = 32'hc76c51a3;
      6'd44: r = 32'hd192e819;  6'd45: r = 32'hd6990624;
      6'd46: r = 32'hf40e3585;  6'd47: r = 32'h106aa070;
      6'd48: r = 32'h19a4c116;  6'd49: r = 32'h1e376c08;
      6'd50: r = 32'h2748774c;  6'd51: r = 32'h34b0bcb5;
      6'd52: r = 32'h391c0cb3;  6'd53: r = 32'h4ed8aa4a;
      6'd54: r = 32'h5b9cca4f;  6'd55: r = 32'h682e6ff3;
      6'd56: r = 32'h748f82ee;  6'd57: r = 32'h78a5636f;
      6'd58: r = 32'h84c87814;  6'd59: r = 32'h8cc70208;
      6'd60: r = 32'h90befffa;  6'd61: r = 32'ha4506ceb;
      6'd62: r = 32'hbef9a3f7;  default: r = 32'hc67178f2;
    endcase
    return r;
  endfunction

endpackage

`default_nettype wire

[hdl/sha256_message_hasher_unit.sv]
// ----------------------------------------------------------------------------
// SHA-256 message hasher
// Byte-stream SHA-256 with padding and a word-serial digest output.
// ----------------------------------------------------------------------------
// Each input beat either absorbs one message byte (in_tuser low, byte in
// in_tdata) or finishes the message (in_tuser high). Absorbed bytes are
// packed into 32-bit words and stored in a 16-word block memory; the
// eight-word chaining value lives in a second 8-word memory. The byte
// completing a 64-byte block starts a compression (loading the schedule
// window and the working variables, 64 rounds at one per cycle, adding back
// into the chaining memory), during which in_tready is low. A finish beat
// pads the message one byte per cycle up to the end of the block (one or two
// final blocks), compresses, and then sends the digest as eight beats, word 0
// (most significant) first, each word read out through S_ORD and S_OLD;
// out_tlast marks word 7. Reading the digest also restores the initial hash
// values, so the next message starts right after. After reset a pass over the
// chaining memory loads the initial hash values before in_tready rises.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

module sha256_message_hasher_unit
  import sha_pkg::*;
(
  input  wire logic        clk,
  input  wire logic        rst_n,
  input  wire logic        in_tvalid,
  output logic             in_tready,
  input  wire logic [7:0]  in_tdata,   // [7:0] data_byte
  input  wire logic        in_tuser,   // func: 0 absorb, 1 finish
  output logic             out_tvalid,
  input  wire logic        out_tready,
  output logic      [39:0] out_tdata,  // [31:0] digest_word, [34:32] word_index
  output logic             out_tlast   // last_word
);

  sha_state_t    state_r, state_nxt;
  logic [5:0]    cnt_r, cnt_nxt;
  logic [5:0]    fill_r, fill_nxt;       // bytes held in the current block
  logic [63:0]   count_r, count_nxt;     // message bytes, modulo 2^64
  logic [63:0]   len_r, len_nxt;         // bit length, shifted out during padding
  logic [23:0]   wbuf_r;                 // bytes of the partial word
  logic          first_r, first_nxt;     // next pad byte is the 0x80 marker
  logic          extra_r, extra_nxt;     // marker did not leave room for the length
  logic          done_r, done_nxt;       // block under compression is the final one
  logic          fin_r, fin_nxt;
  logic [2:0]    oidx_r, oidx_nxt;
  logic [31:0]   oword_r;

  logic          in_acc, byte_en;
  logic [7:0]    byte_val, pad_byte;
  logic          blk_we;
  logic [31:0]   blk_rdata;
  logic          ch_we;
  logic [2:0]    ch_waddr, ch_raddr;
  logic [31:0]   ch_wdata, ch_rdata;
  sha_core_ctl_t core_ctl;
  logic [31:0]   v_word;

  assign in_tready  = (state_r == S_IDLE);
  assign in_acc     = in_tvalid && in_tready;
  assign out_tvalid = (state_r == S_OUT);
  assign out_tdata  = {5'd0, oidx_r, oword_r};
  assign out_tlast  = (oidx_r == 3'd7);

  // Padding bytes: the marker, zeros, then the length in the last eight places
  // of the final block.
  always_comb begin
    if (first_r) begin
      pad_byte = PAD_BYTE;
    end else if (fill_r >= LEN_POS && !extra_r) begin
      pad_byte = len_r[63:56];
    end else begin
      pad_byte = 8'd0;
    end
  end

  assign byte_en  = (in_acc && !in_tuser) || (state_r == S_PAD);
  assign byte_val = (state_r == S_PAD) ? pad_byte : in_tdata;
  assign blk_we   = byte_en && (fill_r[1:0] == 2'd3);

  sha_ram #(.WIDTH(32), .DEPTH(16)) u_blk_ram (
    .clk   (clk),
    .we    (blk_we),
    .waddr (fill_r[5:2]),
    .wdata ({wbuf_r, byte_val}),
    .raddr (cnt_r[3:0]),
    .rdata (blk_rdata)
  );

  // Chaining memory ports.
  always_comb begin
    ch_we    = 1'b0;
    ch_waddr = cnt_r[2:0];
    ch_wdata = init_h(cnt_r[2:0]);
    ch_raddr = cnt_r[2:0];
    unique case (state_r)
      S_INIT: begin
        ch_we = 1'b1;
      end
      S_WB: begin
        ch_we    = (cnt_r != 6'd0);
        ch_waddr = 3'(cnt_r - 6'd1);
        ch_wdata = ch_rdata + v_word;
      end
      S_ORD: begin
        ch_we    = 1'b1;
        ch_waddr = oidx_r;
        ch_wdata = init_h(oidx_r);
        ch_raddr = oidx_r;
      end
      default: begin
      end
    endcase
  end

  sha_ram #(.WIDTH(32), .DEPTH(8)) u_chain_ram (
    .clk   (clk),
    .we    (ch_we),
    .waddr (ch_waddr),
    .wdata (ch_wdata),
    .raddr (ch_raddr),
    .rdata (ch_rdata)
  );

  always_comb begin
    core_ctl.load_w = (state_r == S_LOAD) && (cnt_r != 6'd0);
    core_ctl.load_v = (state_r == S_LOAD) && (cnt_r != 6'd0) && (cnt_r <= 6'd8);
    core_ctl.v_idx  = 3'(cnt_r - 6'd1);
    core_ctl.round  = (state_r == S_ROUND);
    core_ctl.rnd    = cnt_r;
  end

  sha_core u_core (
    .clk   (clk),
    .ctl   (core_ctl),
    .w_in  (blk_rdata),
    .v_in  (ch_rdata),
    .v_out (v_word)
  );

  // Sequencer.
  always_comb begin
    state_nxt = state_r;
    cnt_nxt   = cnt_r;
    fill_nxt  = fill_r;
    count_nxt = count_r;
    len_nxt   = len_r;
    first_nxt = first_r;
    extra_nxt = extra_r;
    done_nxt  = done_r;
    fin_nxt   = fin_r;
    oidx_nxt  = oidx_r;

    if (byte_en) begin
      fill_nxt = fill_r + 6'd1;
      if (state_r == S_PAD) begin
        first_nxt = 1'b0;
        if (!first_r && fill_r >= LEN_POS && !extra_r) begin
          len_nxt = {len_r[55:0], 8'd0};
        end
        if (fill_r == 6'd63) begin
          extra_nxt = 1'b0;
          done_nxt  = !first_r && !extra_r;
        end else if (first_r) begin
          extra_nxt = (fill_r >= LEN_POS);
        end
      end else begin
        count_nxt = count_r + 64'd1;
      end
      if (fill_r == 6'd63) begin
        state_nxt = S_LOAD;
        cnt_nxt   = 6'd0;
      end
    end

    unique case (state_r)
      S_INIT: begin
        cnt_nxt = cnt_r + 6'd1;
        if (cnt_r == 6'd7) begin
          state_nxt = S_IDLE;
          cnt_nxt   = 6'd0;
        end
      end
      S_IDLE: begin
        if (in_acc && in_tuser) begin
          state_nxt = S_PAD;
          len_nxt   = {count_r[60:0], 3'd0};
          count_nxt = 64'd0;
          first_nxt = 1'b1;
          extra_nxt = 1'b0;
          fin_nxt   = 1'b1;
        end
      end
      S_PAD: begin
      end
      S_LOAD: begin
        cnt_nxt = cnt_r + 6'd1;
        if (cnt_r == 6'd16) begin
          state_nxt = S_ROUND;
          cnt_nxt   = 6'd0;
        end
      end
      S_ROUND: begin
        cnt_nxt = cnt_r + 6'd1;
        if (cnt_r == 6'd63) begin
          state_nxt = S_WB;
          cnt_nxt   = 6'd0;
        end
      end
      S_WB: begin
        cnt_nxt = cnt_r + 6'd1;
        if (cnt_r == 6'd8) begin
          cnt_nxt = 6'd0;
          if (done_r) begin
            state_nxt = S_ORD;
            oidx_nxt  = 3'd0;
            done_nxt  = 1'b0;
            fin_nxt   = 1'b0;
          end else if (fin_r) begin
            state_nxt = S_PAD;
          end else begin
            state_nxt = S_IDLE;
          end
        end
      end
      S_ORD: begin
        state_nxt = S_OLD;
      end
      S_OLD: begin
        state_nxt = S_OUT;
      end
      S_OUT: begin
        if (out_tready) begin
          oidx_nxt  = oidx_r + 3'd1;
          state_nxt = (oidx_r == 3'd7) ? S_IDLE : S_ORD;
        end
      end
      default: begin
        state_nxt = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= S_INIT;
      cnt_r   <= 6'd0;
      fill_r  <= 6'd0;
      count_r <= 64'd0;
      first_r <= 1'b0;
      extra_r <= 1'b0;
      done_r  <= 1'b0;
      fin_r   <= 1'b0;
      oidx_r  <= 3'd0;
    end else begin
      state_r <= state_nxt;
      cnt_r   <= cnt_nxt;
      fill_r  <= fill_nxt;
      count_r <= count_nxt;
      first_r <= first_nxt;
      extra_r <= extra_nxt;
      done_r  <= done_nxt;
      fin_r   <= fin_nxt;
      oidx_r  <= oidx_nxt;
    end
  end

  always_ff @(posedge clk) begin
    len_r <= len_nxt;
    if (byte_en) begin
      wbuf_r <= {wbuf_r[15:0], byte_val};
    end
    if (state_r == S_OLD) begin
      oword_r <= ch_rdata;
    end
  end

  // A full set of rounds always hands over to the write-back pass.
  a_round_wb: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == S_ROUND && cnt_r == 6'd63) |=> (state_r == S_WB))
    else $error("round phase did not end in write-back");

  // The final digest word returns the hasher to idle, ready for a new message.
  a_last_idle: assert property (@(posedge clk) disable iff (!rst_n)
    (out_tvalid && out_tready && out_tlast) |=> (state_r == S_IDLE && fill_r == 6'd0))
    else $error("hasher not idle after final digest word");

  // A finish beat always starts padding.
  a_fin_pad: assert property (@(posedge clk) disable iff (!rst_n)
    (in_acc && in_tuser) |=> (state_r == S_PAD && first_r))
    else $error("finish beat did not start padding");

  // The digest is only sent once the final block has been compressed; later
  // words follow the previous output beat.
  a_out_done: assert property (@(posedge clk) disable iff (!rst_n)
    $rose(state_r == S_ORD) |->
      (($past(state_r) == S_WB || $past(state_r) == S_OUT) && !fin_r))
    else $error("digest readout started outside final write-back");

endmodule

`default_nettype wire

[hdl/sha_ram.sv]
// ----------------------------------------------------------------------------
// Generic RAM
// One write port and one read port; read data is registered and returns
// the old contents when the same entry is written in the same cycle.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

module sha_ram #(
  parameter int WIDTH = 32,
  parameter int DEPTH = 16
) (
  input  wire logic                     clk,
  input  wire logic                     we,
  input  wire logic [$clog2(DEPTH)-1:0] waddr,
  input  wire logic [WIDTH-1:0]         wdata,
  input  wire logic [$clog2(DEPTH)-1:0] raddr,
  output logic      [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule

`default_nettype wire

[hdl/sha_core.sv]
// ----------------------------------------------------------------------------
// SHA-256 round datapath
// Sixteen-word message schedule window and the eight working variables;
// one compression round per cycle.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

module sha_core
  import sha_pkg::*;
(
  input  wire logic          clk,
  input  wire sha_core_ctl_t ctl,
  input  wire logic [31:0]   w_in,    // schedule word from the block memory
  input  wire logic [31:0]   v_in,    // chaining word from the chaining memory
  output logic      [31:0]   v_out    // working variable selected by ctl.v_idx
);

  logic [31:0] w_r [16];
  logic [31:0] v_r [8];
  logic [31:0] w_new, t1, t2;

  // The window holds W[t] .. W[t+15]; the next word enters at the top.
  assign w_new = w_r[0] + sml_sig0(w_r[1]) + w_r[9] + sml_sig1(w_r[14]);
  assign t1 = v_r[7] + big_sig1(v_r[4]) + ((v_r[4] & v_r[5]) ^ (~v_r[4] & v_r[6]))
            + round_k(ctl.rnd) + w_r[0];
  assign t2 = big_sig0(v_r[0]) + ((v_r[0] & v_r[1]) ^ (v_r[0] & v_r[2]) ^ (v_r[1] & v_r[2]));
  assign v_out = v_r[ctl.v_idx];

  always_ff @(posedge clk) begin
    if (ctl.load_w || ctl.round) begin
      for (int k = 0; k < 15; k++) begin
        w_r[k] <= w_r[k+1];
      end
      w_r[15] <= ctl.load_w ? w_in : w_new;
    end
    if (ctl.load_v) begin
      v_r[ctl.v_idx] <= v_in;
    end else if (ctl.round) begin
      v_r[7] <= v_r[6];
      v_r[6] <= v_r[5];
      v_r[5] <= v_r[4];
      v_r[4] <= v_r[3] + t1;
      v_r[3] <= v_r[2];
      v_r[2] <= v_r[1];
      v_r[1] <= v_r[0];
      v_r[0] <= t1 + t2;
    end
  end

endmodule

`default_nettype wire

[verif/sha256_message_hasher_unit_test.sv]
// ----------------------------------------------------------------------------
// SHA-256 message hasher testbench
// Drives absorb and finish beats with bursty gaps, predicts every digest word
// with an in-bench SHA-256 and checks the output beats under random stalls.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module sha256_message_hasher_unit_test;

  typedef struct packed {
    logic       func;
    logic [7:0] data_byte;
  } hash_beat_t;

  typedef struct packed {
    logic [31:0] digest_word;
    logic [2:0]  word_index;
    logic        last_word;
  } digest_beat_t;

  localparam logic FUNC_ABSORB = 1'b0;
  localparam logic FUNC_FINISH = 1'b1;

  logic        clk;
  logic        rst_n;
  logic        in_tvalid;
  logic        in_tready;
  logic [7:0]  in_tdata;
  logic        in_tuser;
  logic        out_tvalid;
  logic        out_tready;
  logic [39:0] out_tdata;
  logic        out_tlast;

  sha256_message_hasher_unit dut (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_tvalid (in_tvalid),
    .in_tready (in_tready),
    .in_tdata  (in_tdata),
    .in_tuser  (in_tuser),
    .out_tvalid(out_tvalid),
    .out_tready(out_tready),
    .out_tdata (out_tdata),
    .out_tlast (out_tlast)
  );

  always begin
    clk = 1'b1;
    #1;
    clk = 1'b0;
    #1;
  end

  // Predictor state: chaining words, block buffer, fill level and byte count.
  logic [31:0] hash_words [8];
  logic [7:0]  block_buf [64];
  int unsigned block_fill;
  logic [63:0] msg_bytes;

  hash_beat_t   pending_beats [$];
  digest_beat_t expected_words [$];
  int           error_count;
  bit           in_taken;

  function automatic logic [31:0] ror(logic [31:0] x, int n);
    return (x >> n) | (x << (32 - n));
  endfunction

  function automatic logic [31:0] iv_word(int i);
    logic [31:0] iv [8];
    iv = '{32'h6a09e667, 32'hbb67ae85, 32'h3c6ef372, 32'ha54ff53a,
           32'h510e527f, 32'h9b05688c, 32'h1f83d9ab, 32'h5be0cd19};
    return iv[i];
  endfunction

  function automatic logic [31:0] k_word(int i);
    logic [31:0] k [64];
    k = '{
      32'h428a2f98, 32'h71374491, 32'hb5c0fbcf, 32'he9b5dba5, 32'h3956c25b,
      32'h59f111f1, 32'h923f82a4, 32'hab1c5ed5, 32'hd807aa98, 32'h12835b01,
      32'h243185be, 32'h550c7dc3, 32'h72be5d74, 32'h80deb1fe, 32'h9bdc06a7,
      32'hc19bf174, 32'he49b69c1, 32'hefbe4786, 32'h0fc19dc6, 32'h240ca1cc,
      32'h2de92c6f, 32'h4a7484aa, 32'h5cb0a9dc, 32'h76f988da, 32'h983e5152,
      32'ha831c66d, 32'hb00327c8, 32'hbf597fc7, 32'hc6e00bf3, 32'hd5a79147,
      32'h06ca6351, 32'h14292967, 32'h27b70a85, 32'h2e1b2138, 32'h4d2c6dfc,
      32'h53380d13, 32'h650a7354, 32'h766a0abb, 32'h81c2c92e, 32'h92722c85,
      32'ha2bfe8a1, 32'ha81a664b, 32'hc24b8b70, 32'hc76c51a3, 32'hd192e819,
      32'hd6990624, 32'hf40e3585, 32'h106aa070, 32'h19a4c116, 32'h1e376c08,
      32'h2748774c, 32'h34b0bcb5, 32'h391c0cb3, 32'h4ed8aa4a, 32'h5b9cca4f,
      32'h682e6ff3, 32'h748f82ee, 32'h78a5636f, 32'h84c87814, 32'h8cc70208,
      32'h90befffa, 32'ha4506ceb, 32'hbef9a3f7, 32'hc67178f2};
    return k[i];
  endfunction

  task automatic restart_message();
    for (int i = 0; i < 8; i++) hash_words[i] = iv_word(i);
    block_fill = 0;
    msg_bytes  = '0;
  endtask

  task automatic compress_buffer();
    logic [31:0] w [64];
    logic [31:0] v [8];
    logic [31:0] t1, t2;
    for (int i = 0; i < 16; i++)
      w[i] = {block_buf[4*i], block_buf[4*i+1], block_buf[4*i+2], block_buf[4*i+3]};
    for (int i = 16; i < 64; i++)
      w[i] = w[i-16] + w[i-7]
           + (ror(w[i-15], 7) ^ ror(w[i-15], 18) ^ (w[i-15] >> 3))
           + (ror(w[i-2], 17) ^ ror(w[i-2], 19) ^ (w[i-2] >> 10));
    for (int i = 0; i < 8; i++) v[i] = hash_words[i];
    for (int i = 0; i < 64; i++) begin
      t1 = v[7] + (ror(v[4], 6) ^ ror(v[4], 11) ^ ror(v[4], 25))
         + ((v[4] & v[5]) ^ (~v[4] & v[6])) + k_word(i) + w[i];
      t2 = (ror(v[0], 2) ^ ror(v[0], 13) ^ ror(v[0], 22))
         + ((v[0] & v[1]) ^ (v[0] & v[2]) ^ (v[1] & v[2]));
      v[7] = v[6]; v[6] = v[5]; v[5] = v[4]; v[4] = v[3] + t1;
      v[3] = v[2]; v[2] = v[1]; v[1] = v[0]; v[0] = t1 + t2;
    end
    for (int i = 0; i < 8; i++) hash_words[i] += v[i];
  endtask

  // Advances the predictor by one accepted beat; a finish pads the message
  // and queues the eight digest words.
  task automatic hash_accepted_beat(hash_beat_t b);
    logic [63:0] bit_len;
    digest_beat_t d;
    if (b.func == FUNC_ABSORB) begin
      block_buf[block_fill] = b.data_byte;
      block_fill++;
      msg_bytes++;
      if (block_fill == 64) begin
        compress_buffer();
        block_fill = 0;
      end
    end else begin
      bit_len = msg_bytes << 3;
      block_buf[block_fill] = 8'h80;
      block_fill++;
      // When the pad byte lands in the length field, a second block is needed.
      if (block_fill > 56) begin
        for (int i = block_fill; i < 64; i++) block_buf[i] = '0;
        compress_buffer();
        block_fill = 0;
      end
      for (int i = block_fill; i < 56; i++) block_buf[i] = '0;
      for (int i = 0; i < 8; i++) block_buf[63-i] = bit_len[8*i +: 8];
      compress_buffer();
      for (int i = 0; i < 8; i++) begin
        d.digest_word = hash_words[i];
        d.word_index  = 3'(i);
        d.last_word   = (i == 7);
        expected_words.push_back(d);
      end
      restart_message();
    end
  endtask

  task automatic queue_message(int len);
    hash_beat_t b;
    for (int i = 0; i < len; i++) begin
      b.func      = FUNC_ABSORB;
      b.data_byte = 8'($urandom_range(0, 255));
      pending_beats.push_back(b);
    end
    b.func      = FUNC_FINISH;
    b.data_byte = 8'($urandom_range(0, 255));
    pending_beats.push_back(b);
  endtask

  // Driver: bursts of valid beats separated by random gaps, changed at the
  // falling edge. Valid stays high across back-to-back beats. A beat stays
  // presented until the monitor has seen it accepted.
  int burst_left;
  int gap_left;

  always @(negedge clk) begin
    if (!rst_n) begin
      in_tvalid <= 1'b0;
      in_tdata  <= '0;
      in_tuser  <= 1'b0;
      burst_left = 0;
      gap_left   = 0;
    end else begin
      if (!(in_tvalid && !in_taken)) begin
        if (burst_left == 0 && gap_left == 0) begin
          burst_left = $urandom_range(1, 20);
          gap_left   = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 6);
        end
        if (gap_left > 0 && burst_left == 0) begin
          gap_left--;
          in_tvalid <= 1'b0;
        end else if (pending_beats.size() > 0) begin
          burst_left--;
          in_tvalid <= 1'b1;
          in_tuser  <= pending_beats[0].func;
          in_tdata  <= pending_beats[0].data_byte;
        end else begin
          in_tvalid <= 1'b0;
        end
      end
    end
  end

  // Receiver stall pattern: alternating ready and stalled stretches.
  int stall_left;
  int ready_left;

  always @(negedge clk) begin
    if (!rst_n) begin
      out_tready <= 1'b0;
      stall_left = 0;
      ready_left = 0;
    end else if (ready_left > 0) begin
      ready_left--;
      out_tready <= 1'b1;
    end else if (stall_left > 0) begin
      stall_left--;
      out_tready <= 1'b0;
    end else begin
      ready_left = $urandom_range(1, 12);
      stall_left = ($urandom_range(0, 2) == 0) ? 0 : $urandom_range(1, 8);
      out_tready <= 1'b1;
    end
  end

  // Monitor: the predictor advances on each accepted input beat, and each
  // accepted output beat is checked against the oldest expected word.
  digest_beat_t got;
  digest_beat_t want;

  always @(posedge clk) begin
    in_taken = 1'b0;
    if (rst_n) begin
      if (in_tvalid && in_tready) begin
        in_taken = 1'b1;
        hash_accepted_beat(hash_beat_t'{in_tuser, in_tdata});
        void'(pending_beats.pop_front());
      end
      if (out_tvalid && out_tready) begin
        got.digest_word = out_tdata[31:0];
        got.word_index  = out_tdata[34:32];
        got.last_word   = out_tlast;
        if (expected_words.size() == 0) begin
          $error("digest beat with nothing expected: word %h", got.digest_word);
          error_count++;
        end else begin
          want = expected_words.pop_front();
          if (got.digest_word !== want.digest_word) begin
            $error("digest_word expected %h actual %h", want.digest_word, got.digest_word);
            error_count++;
          end
          if (got.word_index !== want.word_index) begin
            $error("word_index expected %0d actual %0d", want.word_index, got.word_index);
            error_count++;
          end
          if (got.last_word !== want.last_word) begin
            $error("last_word expected %0d actual %0d", want.last_word, got.last_word);
            error_count++;
          end
        end
      end
    end
  end

  initial begin
    hash_beat_t b;
    error_count   = 0;
    in_tvalid     = 1'b0;
    in_tdata      = '0;
    in_tuser      = 1'b0;
    out_tready    = 1'b0;
    restart_message();
    rst_n = 1'b0;
    repeat (5) @(posedge clk);
    rst_n <= 1'b1;

    // Directed: empty message, a finish carrying a nonzero byte, edge byte
    // values, and a message that fills one block by absorbing and then puts
    // the pad byte right on the length field, so two final blocks are used.
    queue_message(0);
    b.func = FUNC_ABSORB; b.data_byte = 8'h00; pending_beats.push_back(b);
    b.data_byte = 8'hff; pending_beats.push_back(b);
    b.func = FUNC_FINISH; b.data_byte = 8'hff; pending_beats.push_back(b);
    queue_message(3);
    queue_message(120);

    // Random short messages.
    for (int n = 0; n < 4; n++)
      queue_message($urandom_range(0, 12));
    // A couple of back-to-back finishes.
    queue_message(0);
    queue_message(0);

    wait (pending_beats.size() == 0);
    wait (expected_words.size() == 0);
    repeat (200) @(posedge clk);
    if (error_count == 0 && expected_words.size() == 0) begin
      $display("== PASS ==");
    end else begin
      $display("== FAIL ==");
    end
    $finish;
  end

  initial begin
    #2000000;
    $display("== FAIL ==");
    $finish;
  end

endmodule
